FILE: rtl/vssl_pkg.sv
// Shared types, codes and helpers for the valve servo slew limiter.
package vssl_pkg;

  localparam int POS_W   = 14;
  localparam int PULSE_W = 12;
  localparam int MS_W    = 10;
  localparam int REQ_W   = 15;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [MS_W-1:0]    ms_t;

  typedef enum logic [2:0] {
    OP_START         = 3'd0,
    OP_CTRL_TARGET   = 3'd1,
    OP_MANUAL_TARGET = 3'd2,
    OP_SET_OVERRIDE  = 3'd3,
    OP_REAPPLY       = 3'd4,
    OP_TICK          = 3'd5
  } vssl_op_t;

  localparam logic [2:0] REG_MIN_PERCENT     = 3'd0;
  localparam logic [2:0] REG_MAX_PERCENT     = 3'd1;
  localparam logic [2:0] REG_CLOSED_PULSE_US = 3'd2;
  localparam logic [2:0] REG_OPEN_PULSE_US   = 3'd3;
  localparam logic [2:0] REG_UPDATE_INTERVAL = 3'd4;
  localparam logic [2:0] REG_MAX_STEP        = 3'd5;

  localparam ms_t    MS_SAT    = '1;
  localparam pulse_t PULSE_SAT = '1;

  typedef struct packed {
    pos_t   min_percent;
    pos_t   max_percent;
    pulse_t closed_pulse_us;
    pulse_t open_pulse_us;
    ms_t    update_interval_ms;
    pos_t   max_step;
  } vssl_cfg_t;

  // Position update handed from the state stage to the pulse pipeline
  typedef struct packed {
    logic emit;
    pos_t cur;
    logic ovr;
    pos_t plim;
  } vssl_upd_t;

  // Finished result beat
  typedef struct packed {
    logic   pulse_valid;
    pulse_t pulse_us;
    pos_t   current_percent;
    logic   override_active;
  } vssl_res_t;

  // Limit to lo first, then to hi, so hi wins when the limits cross
  function automatic pos_t limit_pos(pos_t p, pos_t lo, pos_t hi);
    pos_t r;
    r = (p < lo) ? lo : p;
    r = (r > hi) ? hi : r;
    return r;
  endfunction

endpackage

FILE: rtl/valve_servo_slew_limiter_top.sv
// Top level of the valve servo slew limiter: register port, input stage and result channel.
//
// The block keeps a valve target and a current position in hundredths of a
// percent and moves the position towards the limited target by at most
// max_step on every update_interval_ms-th millisecond tick beat. Each input
// beat carries an operation in in_tuser (start, controller target, manual
// target, set override, reapply limits, tick) and yields exactly one result
// beat with the position, the override flag and, when a new pulse applies,
// the servo pulse width in out_tdata with out_tuser set. Rate: one beat per
// clock in both directions while out_tready is high; all state updates for a
// beat happen in the single state stage, so beats follow one another with no
// gap. A result passes the input register, state stage, pulse numerator,
// reciprocal estimate and result register; every stage holds its own valid bit, so
// the input keeps accepting while a result waits on out_tready until all five stages
// are full. Configuration is to be written through the APB port only while the
// stream is idle; the block does not enforce this. Reads return the register value.
module valve_servo_slew_limiter_top #(
  parameter int POSITION_SCALE = 10000
) (
  input  logic        clk,
  input  logic        rst_n,
  // stream input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] target_percent, [15] override_request
  input  logic [2:0]  in_tuser,   // [2:0] operation
  // stream output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [11:0] pulse_us, [25:12] current_percent,
                                  // [26] override_active, rest zero
  output logic [0:0]  out_tuser,  // [0] pulse_valid
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import vssl_pkg::*;

  vssl_cfg_t cfg_r;
  logic      wr_en;
  logic [2:0] reg_idx;

  // input register
  logic                    s0_vld_r;
  vssl_op_t                s0_op_r;
  logic signed [REQ_W-1:0] s0_tgt_r;
  logic                    s0_ovr_r;
  logic                    s0_rdy;

  logic      core_rdy;
  logic      upd_vld;
  vssl_upd_t upd;
  logic      pulse_rdy;
  logic      res_vld;
  vssl_res_t res;

  // Register port: single wait-free access
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_percent        <= POS_W'(0);
      cfg_r.max_percent        <= POS_W'(10000);
      cfg_r.closed_pulse_us    <= PULSE_W'(1000);
      cfg_r.open_pulse_us      <= PULSE_W'(2000);
      cfg_r.update_interval_ms <= MS_W'(20);
      cfg_r.max_step           <= POS_W'(200);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_PERCENT:     cfg_r.min_percent        <= cfg_pwdata[POS_W-1:0];
        REG_MAX_PERCENT:     cfg_r.max_percent        <= cfg_pwdata[POS_W-1:0];
        REG_CLOSED_PULSE_US: cfg_r.closed_pulse_us    <= cfg_pwdata[PULSE_W-1:0];
        REG_OPEN_PULSE_US:   cfg_r.open_pulse_us      <= cfg_pwdata[PULSE_W-1:0];
        REG_UPDATE_INTERVAL: cfg_r.update_interval_ms <= cfg_pwdata[MS_W-1:0];
        REG_MAX_STEP:        cfg_r.max_step           <= cfg_pwdata[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back: unused addresses return zero
  always_comb begin
    case (reg_idx)
      REG_MIN_PERCENT:     cfg_prdata = 32'(cfg_r.min_percent);
      REG_MAX_PERCENT:     cfg_prdata = 32'(cfg_r.max_percent);
      REG_CLOSED_PULSE_US: cfg_prdata = 32'(cfg_r.closed_pulse_us);
      REG_OPEN_PULSE_US:   cfg_prdata = 32'(cfg_r.open_pulse_us);
      REG_UPDATE_INTERVAL: cfg_prdata = 32'(cfg_r.update_interval_ms);
      REG_MAX_STEP:        cfg_prdata = 32'(cfg_r.max_step);
      default:             cfg_prdata = '0;
    endcase
  end

  // Input register: take a beat whenever it is empty or being drained
  assign s0_rdy    = ~s0_vld_r | core_rdy;
  assign in_tready = s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_tvalid) begin
      s0_op_r  <= vssl_op_t'(in_tuser);
      s0_tgt_r <= $signed(in_tdata[REQ_W-1:0]);
      s0_ovr_r <= in_tdata[REQ_W];
    end
  end

  vssl_core #(
    .POSITION_SCALE (POSITION_SCALE)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_vld  (s0_vld_r),
    .in_op   (s0_op_r),
    .in_tgt  (s0_tgt_r),
    .in_ovr  (s0_ovr_r),
    .in_rdy  (core_rdy),
    .upd_vld (upd_vld),
    .upd     (upd),
    .upd_rdy (pulse_rdy)
  );

  vssl_pulse #(
    .POSITION_SCALE (POSITION_SCALE)
  ) u_pulse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_vld  (upd_vld),
    .in_upd  (upd),
    .in_rdy  (pulse_rdy),
    .out_vld (res_vld),
    .out_res (res),
    .out_rdy (out_tready)
  );

  // Pack the result beat
  assign out_tvalid   = res_vld;
  assign out_tuser[0] = res.pulse_valid;
  assign out_tdata    = {5'd0, res.override_active, res.current_percent, res.pulse_us};

endmodule

FILE: rtl/vssl_core.sv
// State stage: target, position, millisecond counter and flags, one update per beat.
module vssl_core #(
  parameter int POSITION_SCALE = 10000
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  vssl_pkg::vssl_cfg_t     cfg,
  input  logic                    in_vld,
  input  vssl_pkg::vssl_op_t      in_op,
  input  logic signed [14:0]      in_tgt,
  input  logic                    in_ovr,
  output logic                    in_rdy,
  output logic                    upd_vld,
  output vssl_pkg::vssl_upd_t     upd,
  input  logic                    upd_rdy
);
  import vssl_pkg::*;

  localparam logic signed [REQ_W-1:0] SCALE_S = REQ_W'(POSITION_SCALE);
  localparam pos_t                    SCALE_P = POS_W'(POSITION_SCALE);

  pos_t tgt_r, tgt_nxt;
  pos_t cur_r, cur_nxt;
  ms_t  ms_r, ms_nxt;
  logic ovr_r, ovr_nxt;
  logic started_r, started_nxt;
  logic emit;

  logic      upd_vld_r;
  vssl_upd_t upd_r;

  pos_t req_clamp;
  ms_t  ms_inc;
  pos_t goal;
  pos_t diff;
  pos_t step;
  logic adv;

  assign in_rdy = ~upd_vld_r | upd_rdy;
  assign adv    = in_vld & in_rdy;

  always_comb begin
    if (in_tgt < 0) begin
      req_clamp = '0;
    end else if (in_tgt > SCALE_S) begin
      req_clamp = SCALE_P;
    end else begin
      req_clamp = in_tgt[POS_W-1:0];
    end
  end

  always_comb begin
    tgt_nxt     = tgt_r;
    cur_nxt     = cur_r;
    ms_nxt      = ms_r;
    ovr_nxt     = ovr_r;
    started_nxt = started_r;
    emit        = 1'b0;
    ms_inc      = (ms_r < MS_SAT) ? ms_r + 1'b1 : ms_r;
    goal        = limit_pos(tgt_r, cfg.min_percent, cfg.max_percent);
    diff        = (goal > cur_r) ? goal - cur_r : cur_r - goal;
    step        = (diff > cfg.max_step) ? cfg.max_step : diff;
    case (in_op)
      OP_START: begin
        ms_nxt = '0;
        if (!ovr_r) begin
          tgt_nxt = cfg.min_percent;
        end
        cur_nxt     = cfg.min_percent;
        started_nxt = 1'b1;
        emit        = 1'b1;
      end
      OP_CTRL_TARGET: begin
        if (!ovr_r) begin
          tgt_nxt = req_clamp;
        end
      end
      OP_MANUAL_TARGET: begin
        tgt_nxt = req_clamp;
      end
      OP_SET_OVERRIDE: begin
        ovr_nxt = in_ovr;
      end
      OP_REAPPLY: begin
        cur_nxt = limit_pos(cur_r, cfg.min_percent, cfg.max_percent);
        emit    = started_r;
      end
      OP_TICK: begin
        ms_nxt = ms_inc;
        if (ms_inc >= cfg.update_interval_ms) begin
          ms_nxt = '0;
          if (goal != cur_r) begin
            cur_nxt = (goal > cur_r) ? cur_r + step : cur_r - step;
            emit    = started_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r     <= '0;
      cur_r     <= '0;
      ms_r      <= '0;
      ovr_r     <= 1'b0;
      started_r <= 1'b0;
      upd_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        tgt_r     <= tgt_nxt;
        cur_r     <= cur_nxt;
        ms_r      <= ms_nxt;
        ovr_r     <= ovr_nxt;
        started_r <= started_nxt;
      end
      if (in_rdy) begin
        upd_vld_r <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      upd_r.emit <= emit;
      upd_r.cur  <= cur_nxt;
      upd_r.ovr  <= ovr_nxt;
      upd_r.plim <= limit_pos(cur_nxt, cfg.min_percent, cfg.max_percent);
    end
  end

  assign upd_vld = upd_vld_r;
  assign upd     = upd_r;

endmodule

FILE: rtl/vssl_pulse.sv
// Pulse width pipeline: interpolate, divide by the scale through a reciprocal, correct.
module vssl_pulse #(
  parameter int POSITION_SCALE = 10000
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  vssl_pkg::vssl_cfg_t     cfg,
  input  logic                    in_vld,
  input  vssl_pkg::vssl_upd_t     in_upd,
  output logic                    in_rdy,
  output logic                    out_vld,
  output vssl_pkg::vssl_res_t     out_res,
  input  logic                    out_rdy
);
  import vssl_pkg::*;

  localparam int SCALE_W = $clog2(POSITION_SCALE + 1);
  localparam int PROD_W  = (SCALE_W + 13 > 28) ? SCALE_W + 13 : 28;
  localparam int NUM_W   = PROD_W + 1;
  // Below saturation the numerator stays under 4096*scale < 2**NN_W
  localparam int NN_W    = SCALE_W + PULSE_W;
  localparam longint unsigned RECIP = (64'd1 << NN_W) / POSITION_SCALE;
  localparam int RCP_W   = $clog2(RECIP + 1);
  localparam logic [NUM_W-1:0] SCALE_N = NUM_W'(POSITION_SCALE);
  localparam logic [NN_W-1:0]  SCALE_Q = NN_W'(POSITION_SCALE);
  localparam logic signed [NUM_W-1:0] SAT_LIM = NUM_W'(POSITION_SCALE) << PULSE_W;

  // stage 2: numerator
  logic                    s2_vld_r;
  logic signed [NUM_W-1:0] s2_num_r;
  logic                    s2_emit_r;
  pos_t                    s2_cur_r;
  logic                    s2_ovr_r;
  // stage 3: first quotient estimate
  logic                    s3_vld_r;
  logic [NN_W-1:0]         s3_nn_r;
  pulse_t                  s3_q0_r;
  logic                    s3_neg_r;
  logic                    s3_sat_r;
  logic                    s3_emit_r;
  pos_t                    s3_cur_r;
  logic                    s3_ovr_r;
  // stage 4: result register
  logic                    s4_vld_r;
  vssl_res_t               s4_res_r;

  logic s2_rdy, s3_rdy, s4_rdy;

  logic signed [12:0]       span;
  logic signed [REQ_W-1:0]  p_s;
  logic [NUM_W-1:0]         base;
  logic signed [NUM_W-1:0]  swing;
  logic signed [NUM_W-1:0]  num;
  logic [NN_W+RCP_W-1:0]    est;
  logic [NN_W-1:0]          qs;
  logic [NN_W-1:0]          rem;
  pulse_t                   q;
  pulse_t                   pulse;

  assign s4_rdy = ~s4_vld_r | out_rdy;
  assign s3_rdy = ~s3_vld_r | s4_rdy;
  assign s2_rdy = ~s2_vld_r | s3_rdy;
  assign in_rdy = s2_rdy;

  always_comb begin
    span  = $signed({1'b0, cfg.open_pulse_us}) - $signed({1'b0, cfg.closed_pulse_us});
    p_s   = $signed({1'b0, in_upd.plim});
    base  = NUM_W'(cfg.closed_pulse_us) * SCALE_N;
    swing = NUM_W'(span) * NUM_W'(p_s);
    num   = $signed(base) + swing;
  end

  always_comb begin
    est = NN_W'(s2_num_r) * RCP_W'(RECIP);
  end

  always_comb begin
    qs    = NN_W'(s3_q0_r) * SCALE_Q;
    rem   = s3_nn_r - qs;
    q     = (rem >= SCALE_Q) ? s3_q0_r + 1'b1 : s3_q0_r;
    if (!s3_emit_r || s3_neg_r) begin
      pulse = '0;
    end else if (s3_sat_r) begin
      pulse = PULSE_SAT;
    end else begin
      pulse = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_vld_r <= in_vld;
      end
      if (s3_rdy) begin
        s3_vld_r <= s2_vld_r;
      end
      if (s4_rdy) begin
        s4_vld_r <= s3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && in_vld) begin
      s2_num_r  <= num;
      s2_emit_r <= in_upd.emit;
      s2_cur_r  <= in_upd.cur;
      s2_ovr_r  <= in_upd.ovr;
    end
    if (s3_rdy && s2_vld_r) begin
      s3_nn_r   <= s2_num_r[NN_W-1:0];
      s3_q0_r   <= PULSE_W'(est >> NN_W);
      s3_neg_r  <= s2_num_r < 0;
      s3_sat_r  <= s2_num_r >= SAT_LIM;
      s3_emit_r <= s2_emit_r;
      s3_cur_r  <= s2_cur_r;
      s3_ovr_r  <= s2_ovr_r;
    end
    if (s4_rdy && s3_vld_r) begin
      s4_res_r.pulse_valid     <= s3_emit_r;
      s4_res_r.pulse_us        <= pulse;
      s4_res_r.current_percent <= s3_cur_r;
      s4_res_r.override_active <= s3_ovr_r;
    end
  end

  assign out_vld = s4_vld_r;
  assign out_res = s4_res_r;

endmodule
